// ----- rtl/tls_sni_extractor_macros.svh -----
// assertion macros for the tls sni extractor
// used by the top level only, no other dependencies
`ifndef TLS_SNI_EXTRACTOR_MACROS_SVH
`define TLS_SNI_EXTRACTOR_MACROS_SVH

// implication check, disabled during reset
`define TSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication check, disabled during reset
`define TSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tse_pkg.sv -----
// shared types and constants for the tls sni extractor
// no dependencies
package tse_pkg;

    localparam int unsigned MaxRecordReset = 16'h4000;
    localparam int unsigned CsCapacity     = ((16'hFFFF - 1) / 2) * 2;

    localparam logic [1:0] KIND_NAME_BYTE  = 2'd0;
    localparam logic [1:0] KIND_EMPTY_NAME = 2'd1;
    localparam logic [1:0] KIND_DONE       = 2'd2;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        payload_first;
        logic [15:0] payload_len;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  name_byte;
        logic        name_first;
        logic        name_last;
        logic [15:0] consumed;
        logic        run_last;
    } t_out_item;

    typedef enum logic [19:0] {
        PH_IDLE         = 20'd1 << 0,
        PH_DRAIN        = 20'd1 << 1,
        PH_REC_HDR      = 20'd1 << 2,
        PH_SKIP_REC     = 20'd1 << 3,
        PH_ALERT        = 20'd1 << 4,
        PH_HS_HDR       = 20'd1 << 5,
        PH_HS_SKIP      = 20'd1 << 6,
        PH_CH_INTRO     = 20'd1 << 7,
        PH_CH_SID_LEN   = 20'd1 << 8,
        PH_CH_SID       = 20'd1 << 9,
        PH_CH_CS_LEN    = 20'd1 << 10,
        PH_CH_CS        = 20'd1 << 11,
        PH_CH_COMP_LEN  = 20'd1 << 12,
        PH_CH_COMP      = 20'd1 << 13,
        PH_CH_EXT_LEN   = 20'd1 << 14,
        PH_EXT_HDR      = 20'd1 << 15,
        PH_EXT_SKIP     = 20'd1 << 16,
        PH_SNI_LIST_LEN = 20'd1 << 17,
        PH_SNI_HDR      = 20'd1 << 18,
        PH_SNI_NAME     = 20'd1 << 19
    } t_phase;

    // parser to result queue: up to two results per beat
    typedef struct packed {
        logic      valid0;
        logic      valid1;
        t_out_item res0;
        t_out_item res1;
    } t_res_pair;

endpackage

// ----- rtl/tse_parser.sv -----
// front part: walks tls records one payload byte per cycle while i_valid is high
// depends on tse_pkg
module tse_parser #(
    parameter int PAYLOAD_LEN_BITS = 16,
    parameter int MAX_SESSION_ID   = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_wdata,
    input  logic                 i_valid,
    input  tse_pkg::t_in_item    i_item,
    output tse_pkg::t_res_pair   o_res
);

    localparam int LB = PAYLOAD_LEN_BITS;

    tse_pkg::t_phase r_phase, n_phase;
    logic [LB-1:0]   r_pl_left, n_pl_left, r_pl_total, n_pl_total;
    logic [LB-1:0]   r_ckpt, n_ckpt;
    logic [15:0]     r_fcount, n_fcount;
    logic [23:0]     r_facc, n_facc;
    logic [15:0]     r_rec_left, n_rec_left;
    logic [7:0]      r_rtype, n_rtype;
    logic [23:0]     r_msg_left, n_msg_left;
    logic [15:0]     r_ext_left, n_ext_left;
    logic [15:0]     r_nl_left, n_nl_left;
    logic            r_failed, n_failed;
    logic [15:0]     r_max_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rec <= 16'(tse_pkg::MaxRecordReset);
        end else if (i_cfg_we) begin
            r_max_rec <= i_cfg_wdata;
        end
    end

    function automatic logic hs_skip_type(input logic [7:0] t);
        return (t == 8'd0) || (t == 8'd2) || (t >= 8'd11 && t <= 8'd16) || (t == 8'd20);
    endfunction

    function automatic tse_pkg::t_out_item mk(input logic [1:0] k, input logic [7:0] b,
                                              input logic f, input logic l,
                                              input logic [15:0] c);
        tse_pkg::t_out_item o;
        o.kind = k; o.name_byte = b; o.name_first = f; o.name_last = l;
        o.consumed = c; o.run_last = 1'b0;
        return o;
    endfunction

    always_comb begin
        logic [7:0]  b;
        logic        go;
        logic        r0v, r1v;
        tse_pkg::t_out_item r0, r1;
        logic [23:0] acc_sh;
        logic [15:0] cnt_inc;
        logic [15:0] v16;
        logic [23:0] fdec;
        // flattened next-step chain requests
        logic        do_record_done, do_hs_next, do_ext_next, do_sni_next;
        logic        do_after_sid, do_after_cs, do_after_comp;
        logic        do_stop;
        logic [LB-1:0] pl_after;
        b = i_item.data_byte;
        n_phase = r_phase; n_pl_left = r_pl_left; n_pl_total = r_pl_total;
        n_ckpt = r_ckpt; n_fcount = r_fcount; n_facc = r_facc;
        n_rec_left = r_rec_left; n_rtype = r_rtype; n_msg_left = r_msg_left;
        n_ext_left = r_ext_left; n_nl_left = r_nl_left; n_failed = r_failed;
        r0v = 1'b0; r1v = 1'b0;
        r0 = '0; r1 = '0;
        go = 1'b0;
        do_record_done = 1'b0; do_hs_next = 1'b0; do_ext_next = 1'b0;
        do_sni_next = 1'b0; do_after_sid = 1'b0; do_after_cs = 1'b0;
        do_after_comp = 1'b0; do_stop = 1'b0;
        acc_sh = '0; cnt_inc = '0; v16 = '0; fdec = '0; pl_after = '0;

        if (i_valid) begin
            if (i_item.payload_first) begin
                n_pl_total = LB'(i_item.payload_len);
                n_pl_left  = LB'(i_item.payload_len);
                n_ckpt = '0; n_failed = 1'b0;
                n_fcount = '0; n_facc = '0; n_rec_left = '0; n_rtype = '0;
                n_msg_left = '0; n_ext_left = '0; n_nl_left = '0;
                if (n_pl_left == '0) begin
                    n_phase = tse_pkg::PH_IDLE;
                    r0v = 1'b1;
                    r0 = mk(tse_pkg::KIND_DONE, 8'd0, 1'b0, 1'b0, 16'd0);
                end else begin
                    go = 1'b1;
                    if (n_pl_left < LB'(5)) begin
                        n_failed = 1'b1; n_phase = tse_pkg::PH_DRAIN;
                    end else begin
                        n_phase = tse_pkg::PH_REC_HDR;
                    end
                end
            end else if (r_phase != tse_pkg::PH_IDLE) begin
                go = 1'b1;
            end
        end

        if (go) begin
            tse_pkg::t_phase ph;
            ph = n_phase;
            n_pl_left = n_pl_left - LB'(1);
            pl_after = n_pl_left;
            if (ph != tse_pkg::PH_DRAIN && ph != tse_pkg::PH_IDLE) begin
                if (ph != tse_pkg::PH_REC_HDR) n_rec_left = n_rec_left - 16'd1;
                if (ph inside {tse_pkg::PH_HS_SKIP, tse_pkg::PH_CH_INTRO,
                               tse_pkg::PH_CH_SID_LEN, tse_pkg::PH_CH_SID,
                               tse_pkg::PH_CH_CS_LEN, tse_pkg::PH_CH_CS,
                               tse_pkg::PH_CH_COMP_LEN, tse_pkg::PH_CH_COMP,
                               tse_pkg::PH_CH_EXT_LEN, tse_pkg::PH_EXT_HDR,
                               tse_pkg::PH_EXT_SKIP, tse_pkg::PH_SNI_LIST_LEN,
                               tse_pkg::PH_SNI_HDR, tse_pkg::PH_SNI_NAME})
                    n_msg_left = n_msg_left - 24'd1;
                if (ph inside {tse_pkg::PH_EXT_HDR, tse_pkg::PH_EXT_SKIP,
                               tse_pkg::PH_SNI_LIST_LEN, tse_pkg::PH_SNI_HDR,
                               tse_pkg::PH_SNI_NAME})
                    n_ext_left = n_ext_left - 16'd1;
                if (ph inside {tse_pkg::PH_SNI_HDR, tse_pkg::PH_SNI_NAME})
                    n_nl_left = n_nl_left - 16'd1;

                acc_sh  = {n_facc[15:0], b};
                cnt_inc = n_fcount + 16'd1;
                fdec    = n_facc - 24'd1;

                case (ph)
                    tse_pkg::PH_REC_HDR: begin
                        if (n_fcount == 16'd0) n_rtype = b;
                        n_facc = acc_sh; n_fcount = cnt_inc;
                        if (cnt_inc >= 16'd5) begin
                            v16 = acc_sh[15:0];
                            if (v16 > r_max_rec || 32'(pl_after) < 32'(v16)) begin
                                do_stop = 1'b1;
                            end else begin
                                n_rec_left = v16;
                                if (n_rtype == 8'd20 || n_rtype == 8'd23) begin
                                    if (v16 == 16'd0) do_record_done = 1'b1;
                                    else n_phase = tse_pkg::PH_SKIP_REC;
                                end else if (n_rtype == 8'd21) begin
                                    if (v16 == 16'd0) do_record_done = 1'b1;
                                    else if (v16 < 16'd2) do_stop = 1'b1;
                                    else begin
                                        n_phase = tse_pkg::PH_ALERT;
                                        n_fcount = '0; n_facc = '0;
                                    end
                                end else if (n_rtype == 8'd22) begin
                                    do_hs_next = 1'b1;
                                end else begin
                                    do_stop = 1'b1;
                                end
                            end
                        end
                    end
                    tse_pkg::PH_SKIP_REC: begin
                        if (n_rec_left == 16'd0) do_record_done = 1'b1;
                    end
                    tse_pkg::PH_ALERT: begin
                        if (n_fcount == 16'd0) begin
                            n_facc = {16'd0, b}; n_fcount = 16'd1;
                        end else if (!(n_facc == 24'd1 || n_facc == 24'd2) ||
                                     !(b == 8'd0 || b == 8'd10 || b == 8'd20)) begin
                            do_stop = 1'b1;
                        end else if (n_rec_left == 16'd0) begin
                            do_record_done = 1'b1;
                        end else if (n_rec_left < 16'd2) begin
                            do_stop = 1'b1;
                        end else begin
                            n_fcount = '0; n_facc = '0;
                        end
                    end
                    tse_pkg::PH_HS_HDR: begin
                        if (n_fcount == 16'd0) n_rtype = b;
                        n_facc = acc_sh; n_fcount = cnt_inc;
                        if (cnt_inc >= 16'd4) begin
                            if ({8'd0, n_rec_left} < acc_sh) begin
                                do_stop = 1'b1;
                            end else if (n_rtype == 8'd1) begin
                                if (acc_sh < 24'd34) do_stop = 1'b1;
                                else begin
                                    n_msg_left = acc_sh;
                                    n_phase = tse_pkg::PH_CH_INTRO;
                                    n_facc = 24'd34; n_fcount = '0;
                                end
                            end else if (hs_skip_type(n_rtype)) begin
                                n_msg_left = acc_sh;
                                if (acc_sh == 24'd0) do_hs_next = 1'b1;
                                else n_phase = tse_pkg::PH_HS_SKIP;
                            end else begin
                                do_stop = 1'b1;
                            end
                        end
                    end
                    tse_pkg::PH_HS_SKIP: begin
                        if (n_msg_left == 24'd0) do_hs_next = 1'b1;
                    end
                    tse_pkg::PH_CH_INTRO: begin
                        n_facc = fdec;
                        if (fdec == 24'd0) begin
                            if (n_msg_left < 24'd1) do_stop = 1'b1;
                            else begin
                                n_phase = tse_pkg::PH_CH_SID_LEN;
                                n_fcount = '0; n_facc = '0;
                            end
                        end
                    end
                    tse_pkg::PH_CH_SID_LEN: begin
                        if (n_msg_left < {16'd0, b} || 32'(b) > 32'(MAX_SESSION_ID))
                            do_stop = 1'b1;
                        else if (b == 8'd0) do_after_sid = 1'b1;
                        else begin
                            n_phase = tse_pkg::PH_CH_SID;
                            n_facc = {16'd0, b}; n_fcount = '0;
                        end
                    end
                    tse_pkg::PH_CH_CS_LEN: begin
                        n_facc = acc_sh; n_fcount = cnt_inc;
                        if (cnt_inc >= 16'd2) begin
                            v16 = acc_sh[15:0];
                            if (n_msg_left < {8'd0, v16} ||
                                32'(v16) > 32'(tse_pkg::CsCapacity))
                                do_stop = 1'b1;
                            else if (v16 == 16'd0) do_after_cs = 1'b1;
                            else begin
                                n_phase = tse_pkg::PH_CH_CS;
                                n_facc = {8'd0, v16}; n_fcount = '0;
                            end
                        end
                    end
                    tse_pkg::PH_CH_COMP_LEN: begin
                        if (n_msg_left < {16'd0, b}) do_stop = 1'b1;
                        else if (b == 8'd0) do_after_comp = 1'b1;
                        else begin
                            n_phase = tse_pkg::PH_CH_COMP;
                            n_facc = {16'd0, b}; n_fcount = '0;
                        end
                    end
                    tse_pkg::PH_CH_SID, tse_pkg::PH_CH_CS, tse_pkg::PH_CH_COMP,
                    tse_pkg::PH_EXT_SKIP: begin
                        n_facc = fdec;
                        if (fdec == 24'd0) begin
                            case (ph)
                                tse_pkg::PH_CH_SID:  do_after_sid = 1'b1;
                                tse_pkg::PH_CH_CS:   do_after_cs = 1'b1;
                                tse_pkg::PH_CH_COMP: do_after_comp = 1'b1;
                                default:             do_ext_next = 1'b1;
                            endcase
                        end
                    end
                    tse_pkg::PH_CH_EXT_LEN: begin
                        n_facc = acc_sh; n_fcount = cnt_inc;
                        if (cnt_inc >= 16'd2) begin
                            v16 = acc_sh[15:0];
                            if (n_msg_left < {8'd0, v16} || v16 == 16'd0) do_stop = 1'b1;
                            else begin
                                n_ext_left = v16;
                                do_ext_next = 1'b1;
                            end
                        end
                    end
                    tse_pkg::PH_EXT_HDR: begin
                        n_facc = acc_sh; n_fcount = cnt_inc;
                        v16 = acc_sh[15:0];
                        if (cnt_inc == 16'd2) begin
                            n_nl_left = v16;
                        end else if (cnt_inc >= 16'd4) begin
                            if (n_ext_left < v16) do_stop = 1'b1;
                            else if (n_nl_left == 16'd0) begin
                                if (v16 < 16'd2) do_stop = 1'b1;
                                else begin
                                    n_nl_left = v16;
                                    n_phase = tse_pkg::PH_SNI_LIST_LEN;
                                    n_fcount = '0; n_facc = '0;
                                end
                            end else if (v16 == 16'd0) do_ext_next = 1'b1;
                            else begin
                                n_phase = tse_pkg::PH_EXT_SKIP;
                                n_facc = {8'd0, v16}; n_fcount = '0;
                            end
                        end
                    end
                    tse_pkg::PH_SNI_LIST_LEN: begin
                        n_facc = acc_sh; n_fcount = cnt_inc;
                        if (cnt_inc >= 16'd2) begin
                            v16 = acc_sh[15:0];
                            if (n_nl_left < 16'd2 || v16 > n_nl_left - 16'd2) do_stop = 1'b1;
                            else begin
                                n_nl_left = v16;
                                do_sni_next = 1'b1;
                            end
                        end
                    end
                    tse_pkg::PH_SNI_HDR: begin
                        n_facc = acc_sh; n_fcount = cnt_inc;
                        if (cnt_inc >= 16'd3) begin
                            v16 = acc_sh[15:0];
                            if (n_nl_left < v16) do_stop = 1'b1;
                            else if (v16 == 16'd0) begin
                                r0v = 1'b1;
                                r0 = mk(tse_pkg::KIND_EMPTY_NAME, 8'd0, 1'b1, 1'b1, 16'd0);
                                do_sni_next = 1'b1;
                            end else begin
                                n_phase = tse_pkg::PH_SNI_NAME;
                                n_facc = {8'd0, v16}; n_fcount = '0;
                            end
                        end
                    end
                    tse_pkg::PH_SNI_NAME: begin
                        r0v = 1'b1;
                        r0 = mk(tse_pkg::KIND_NAME_BYTE, b, n_fcount == 16'd0,
                                n_facc == 24'd1, 16'd0);
                        n_facc = fdec; n_fcount = cnt_inc;
                        if (fdec == 24'd0) do_sni_next = 1'b1;
                    end
                    default: do_stop = 1'b1;
                endcase

                // resolve the chain of "what comes next" decisions
                if (do_after_sid) begin
                    if (n_msg_left < 24'd2) do_stop = 1'b1;
                    else begin
                        n_phase = tse_pkg::PH_CH_CS_LEN; n_fcount = '0; n_facc = '0;
                    end
                end
                if (do_after_cs) begin
                    if (n_msg_left < 24'd1) do_stop = 1'b1;
                    else begin
                        n_phase = tse_pkg::PH_CH_COMP_LEN; n_fcount = '0; n_facc = '0;
                    end
                end
                if (do_after_comp) begin
                    if (n_msg_left == 24'd0) do_hs_next = 1'b1;
                    else if (n_msg_left < 24'd2) do_stop = 1'b1;
                    else begin
                        n_phase = tse_pkg::PH_CH_EXT_LEN; n_fcount = '0; n_facc = '0;
                    end
                end
                if (do_sni_next) begin
                    if (n_nl_left == 16'd0) do_ext_next = 1'b1;
                    else if (n_nl_left < 16'd3) do_stop = 1'b1;
                    else begin
                        n_phase = tse_pkg::PH_SNI_HDR; n_fcount = '0; n_facc = '0;
                    end
                end
                if (do_ext_next) begin
                    if (n_ext_left == 16'd0) do_hs_next = 1'b1;
                    else if (n_ext_left < 16'd4) do_stop = 1'b1;
                    else begin
                        n_phase = tse_pkg::PH_EXT_HDR; n_fcount = '0; n_facc = '0;
                    end
                end
                if (do_hs_next) begin
                    if (n_rec_left == 16'd0) do_record_done = 1'b1;
                    else if (n_rec_left < 16'd4) do_stop = 1'b1;
                    else begin
                        n_phase = tse_pkg::PH_HS_HDR; n_fcount = '0; n_facc = '0;
                    end
                end
                if (do_record_done) begin
                    n_ckpt = n_pl_total - n_pl_left;
                    if (n_pl_left == '0) n_phase = tse_pkg::PH_DRAIN;
                    else if (n_pl_left < LB'(5)) do_stop = 1'b1;
                    else begin
                        n_phase = tse_pkg::PH_REC_HDR; n_fcount = '0; n_facc = '0;
                    end
                end
                if (do_stop) begin
                    n_failed = 1'b1; n_phase = tse_pkg::PH_DRAIN;
                end
            end

            if (n_pl_left == '0) begin
                if (r0v) begin
                    r1v = 1'b1;
                    r1 = mk(tse_pkg::KIND_DONE, 8'd0, 1'b0, 1'b0, 16'(n_ckpt));
                end else begin
                    r0v = 1'b1;
                    r0 = mk(tse_pkg::KIND_DONE, 8'd0, 1'b0, 1'b0, 16'(n_ckpt));
                end
                n_phase = tse_pkg::PH_IDLE;
            end
        end

        if (r1v) r1.run_last = 1'b1;
        else if (r0v) r0.run_last = 1'b1;
        o_res.valid0 = r0v;
        o_res.valid1 = r1v;
        o_res.res0 = r0;
        o_res.res1 = r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tse_pkg::PH_IDLE;
            r_pl_left <= '0; r_pl_total <= '0; r_ckpt <= '0;
            r_fcount <= '0; r_facc <= '0; r_rec_left <= '0; r_rtype <= '0;
            r_msg_left <= '0; r_ext_left <= '0; r_nl_left <= '0; r_failed <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pl_left <= n_pl_left; r_pl_total <= n_pl_total; r_ckpt <= n_ckpt;
            r_fcount <= n_fcount; r_facc <= n_facc; r_rec_left <= n_rec_left;
            r_rtype <= n_rtype; r_msg_left <= n_msg_left; r_ext_left <= n_ext_left;
            r_nl_left <= n_nl_left; r_failed <= n_failed;
        end
    end

endmodule

// ----- rtl/tse_out_queue.sv -----
// back part: result queue taking up to two results per beat
// depends on tse_pkg
module tse_out_queue #(
    parameter int DEPTH_BITS = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tse_pkg::t_res_pair   i_res,
    output logic                 o_room,
    output logic                 o_empty,
    output tse_pkg::t_out_item   o_item,
    input  logic                 i_pop,
    output logic [DEPTH_BITS:0]  o_count
);

    localparam int Depth = 1 << DEPTH_BITS;

    tse_pkg::t_out_item r_mem [Depth];
    logic [DEPTH_BITS-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [DEPTH_BITS:0]   r_cnt, n_cnt;
    logic                  do_pop;
    logic [1:0]            n_push;

    assign do_pop  = i_pop && (r_cnt != '0);
    assign n_push  = {1'b0, i_res.valid0} + {1'b0, i_res.valid1};
    // at least two free entries: room for the results of one more beat
    assign o_room  = r_cnt <= (DEPTH_BITS+1)'(Depth - 2);
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];
    assign o_count = r_cnt;

    always_comb begin
        n_rp  = r_rp + DEPTH_BITS'(do_pop);
        n_wp  = r_wp + DEPTH_BITS'(n_push);
        n_cnt = r_cnt + (DEPTH_BITS+1)'(n_push) - (DEPTH_BITS+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_res.valid0) r_mem[r_wp] <= i_res.res0;
        if (i_res.valid1) r_mem[r_wp + DEPTH_BITS'(1)] <= i_res.res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp <= n_wp; r_rp <= n_rp; r_cnt <= n_cnt;
        end
    end

endmodule

// ----- rtl/tls_sni_extractor.sv -----
// Usage: a tls client hello server name extractor.
// Input channel: push / full, one payload byte per beat in i_in; the first beat of a
// payload has payload_first set and carries the payload length.
// Result channel: empty / pop, results in o_out: host name bytes with first and last
// marks, empty host name marks, and one done result per payload with the byte count of
// fully parsed records. run_last marks the last result caused by one input beat.
// Configuration: i_cfg_we / i_cfg_wdata write the largest accepted record length.
// A result is written into the output queue by the beat that caused it.
// Throughput: one byte per cycle while full is low; the parser takes one byte each cycle with its full
// phase and counter update, and results go through a four-entry queue.
// A stalled receiver fills the queue; full rises once fewer than two entries are free.
// Reset clears the parser to idle, empties the queue and restores the record limit
// to 16384.
// Depends on tse_pkg, tse_parser, tse_out_queue and the macros header.
`include "tls_sni_extractor_macros.svh"
module tls_sni_extractor #(
    parameter int PAYLOAD_LEN_BITS = 16,
    parameter int MAX_SESSION_ID   = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               push,
    output logic               full,
    input  tse_pkg::t_in_item  i_in,
    output logic               empty,
    input  logic               pop,
    output tse_pkg::t_out_item o_out
);

    tse_pkg::t_res_pair res;
    logic               room;
    logic [2:0]         q_count;

    assign full = !room;

    tse_parser #(
        .PAYLOAD_LEN_BITS(PAYLOAD_LEN_BITS),
        .MAX_SESSION_ID  (MAX_SESSION_ID)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (push && room),
        .i_item     (i_in),
        .o_res      (res)
    );

    tse_out_queue #(.DEPTH_BITS(2)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_res  (res),
        .o_room (room),
        .o_empty(empty),
        .o_item (o_out),
        .i_pop  (pop),
        .o_count(q_count)
    );

    `TSE_ASSERT_IMP(a_second_needs_first, i_clk, i_rst_n, res.valid1, res.valid0,
        "second result without first")
    `TSE_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, res.valid0, q_count <= 3'd3,
        "result queue overflow")
    `TSE_ASSERT_IMP(a_idle_no_result, i_clk, i_rst_n, !(push && !full),
        !res.valid0, "result without accepted beat")
    `TSE_ASSERT_NXT(a_last_pop_empties, i_clk, i_rst_n,
        pop && !empty && !res.valid0 && q_count == 3'd1, empty,
        "queue not empty after last pop")

endmodule

// ----- dv/tls_sni_extractor_test.sv -----
// self-checking testbench for tls_sni_extractor: random tls payloads with client hellos,
// a bit-accurate parser predictor, and a result checker on the output queue
// depends on tse_pkg and the tls_sni_extractor top level
module tls_sni_extractor_test;

    localparam int MaxSid       = 32;
    localparam int IdleLimit    = 4000;
    localparam int PhaseItems   = 300;
    localparam int DrainCycles  = 12;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [15:0]        i_cfg_wdata = 16'd0;
    logic               push = 1'b0;
    logic               full;
    tse_pkg::t_in_item  i_in = '0;
    logic               empty;
    logic               pop = 1'b0;
    tse_pkg::t_out_item o_out;

    tls_sni_extractor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out)
    );

    always #1 i_clk = ~i_clk;

    tse_pkg::t_in_item  byte_feed[$];
    tse_pkg::t_out_item sni_results_q[$];
    logic [7:0]  pkt[$];
    int          errors = 0;
    int          rx_count = 0;
    int          items_sent = 0;

    // predictor state
    tse_pkg::t_phase m_phase = tse_pkg::PH_IDLE;
    logic [15:0] m_max_rec = 16'(tse_pkg::MaxRecordReset);
    logic [15:0] m_left, m_total, m_cnt, m_rec, m_ext, m_names, m_ckpt;
    logic [23:0] m_acc, m_msg;
    logic [7:0]  m_rtype;
    int          m_emitted;

    function automatic void push_result(logic [1:0] k, logic [7:0] b, logic f, logic l,
                                        logic [15:0] c);
        tse_pkg::t_out_item r;
        r.kind = k; r.name_byte = b; r.name_first = f; r.name_last = l;
        r.consumed = c; r.run_last = 1'b0;
        sni_results_q.push_back(r);
        m_emitted++;
    endfunction

    function automatic void halt_parse();
        m_phase = tse_pkg::PH_DRAIN;
    endfunction

    function automatic void open_field(tse_pkg::t_phase ph);
        m_phase = ph; m_cnt = 0; m_acc = 0;
    endfunction

    function automatic void open_skip(tse_pkg::t_phase ph, logic [23:0] n);
        m_phase = ph; m_acc = n; m_cnt = 0;
    endfunction

    function automatic void next_record();
        if (m_left == 0) m_phase = tse_pkg::PH_DRAIN;
        else if (m_left < 5) halt_parse();
        else open_field(tse_pkg::PH_REC_HDR);
    endfunction

    function automatic void close_record();
        m_ckpt = m_total - m_left;
        next_record();
    endfunction

    function automatic void next_handshake();
        if (m_rec == 0) close_record();
        else if (m_rec < 4) halt_parse();
        else open_field(tse_pkg::PH_HS_HDR);
    endfunction

    function automatic void next_extension();
        if (m_ext == 0) next_handshake();
        else if (m_ext < 4) halt_parse();
        else open_field(tse_pkg::PH_EXT_HDR);
    endfunction

    function automatic void next_name();
        if (m_names == 0) next_extension();
        else if (m_names < 3) halt_parse();
        else open_field(tse_pkg::PH_SNI_HDR);
    endfunction

    function automatic void after_session_id();
        if (m_msg < 2) halt_parse(); else open_field(tse_pkg::PH_CH_CS_LEN);
    endfunction

    function automatic void after_suites();
        if (m_msg < 1) halt_parse(); else open_field(tse_pkg::PH_CH_COMP_LEN);
    endfunction

    function automatic void after_compression();
        if (m_msg == 0) next_handshake();
        else if (m_msg < 2) halt_parse();
        else open_field(tse_pkg::PH_CH_EXT_LEN);
    endfunction

    function automatic void shift_in(logic [7:0] b);
        m_acc = {m_acc[15:0], b};
        m_cnt = m_cnt + 1;
    endfunction

    function automatic logic hs_skipped(logic [7:0] t);
        return t == 0 || t == 2 || (t >= 11 && t <= 16) || t == 20;
    endfunction

    function automatic void parse_payload_byte(logic [7:0] b);
        tse_pkg::t_phase ph;
        logic [23:0]     v;
        ph = m_phase;
        m_left = m_left - 1;
        if (ph == tse_pkg::PH_DRAIN || ph == tse_pkg::PH_IDLE) return;
        // one-hot codes grow with the nesting depth of the phase
        if (ph != tse_pkg::PH_REC_HDR) m_rec = m_rec - 1;
        if (ph >= tse_pkg::PH_HS_SKIP) m_msg = m_msg - 1;
        if (ph >= tse_pkg::PH_EXT_HDR) m_ext = m_ext - 1;
        if (ph >= tse_pkg::PH_SNI_HDR) m_names = m_names - 1;
        case (ph)
            tse_pkg::PH_REC_HDR: begin
                if (m_cnt == 0) m_rtype = b;
                shift_in(b);
                if (m_cnt < 5) return;
                v = {8'd0, m_acc[15:0]};
                if (v > m_max_rec || m_left < v) begin halt_parse(); return; end
                m_rec = v[15:0];
                if (m_rtype == 20 || m_rtype == 23) begin
                    if (v == 0) close_record(); else m_phase = tse_pkg::PH_SKIP_REC;
                end else if (m_rtype == 21) begin
                    if (v == 0) close_record();
                    else if (v < 2) halt_parse();
                    else open_field(tse_pkg::PH_ALERT);
                end else if (m_rtype == 22) begin
                    next_handshake();
                end else begin
                    halt_parse();
                end
            end
            tse_pkg::PH_SKIP_REC: if (m_rec == 0) close_record();
            tse_pkg::PH_ALERT: begin
                if (m_cnt == 0) begin m_acc = {16'd0, b}; m_cnt = 1; return; end
                if (!(m_acc == 1 || m_acc == 2) || !(b == 0 || b == 10 || b == 20))
                    halt_parse();
                else if (m_rec == 0) close_record();
                else if (m_rec < 2) halt_parse();
                else open_field(tse_pkg::PH_ALERT);
            end
            tse_pkg::PH_HS_HDR: begin
                if (m_cnt == 0) m_rtype = b;
                shift_in(b);
                if (m_cnt < 4) return;
                v = m_acc;
                if (m_rec < v) begin halt_parse(); return; end
                if (m_rtype == 1) begin
                    if (v < 34) begin halt_parse(); return; end
                    m_msg = v;
                    open_skip(tse_pkg::PH_CH_INTRO, 24'd34);
                end else if (hs_skipped(m_rtype)) begin
                    m_msg = v;
                    if (v == 0) next_handshake(); else m_phase = tse_pkg::PH_HS_SKIP;
                end else begin
                    halt_parse();
                end
            end
            tse_pkg::PH_HS_SKIP: if (m_msg == 0) next_handshake();
            tse_pkg::PH_CH_INTRO: begin
                m_acc = m_acc - 1;
                if (m_acc == 0) begin
                    if (m_msg < 1) halt_parse(); else open_field(tse_pkg::PH_CH_SID_LEN);
                end
            end
            tse_pkg::PH_CH_SID_LEN: begin
                if (m_msg < b || b > MaxSid) halt_parse();
                else if (b == 0) after_session_id();
                else open_skip(tse_pkg::PH_CH_SID, {16'd0, b});
            end
            tse_pkg::PH_CH_CS_LEN: begin
                shift_in(b);
                if (m_cnt < 2) return;
                v = {8'd0, m_acc[15:0]};
                if (m_msg < v || v > tse_pkg::CsCapacity) halt_parse();
                else if (v == 0) after_suites();
                else open_skip(tse_pkg::PH_CH_CS, v);
            end
            tse_pkg::PH_CH_COMP_LEN: begin
                if (m_msg < b) halt_parse();
                else if (b == 0) after_compression();
                else open_skip(tse_pkg::PH_CH_COMP, {16'd0, b});
            end
            tse_pkg::PH_CH_SID, tse_pkg::PH_CH_CS, tse_pkg::PH_CH_COMP,
            tse_pkg::PH_EXT_SKIP: begin
                m_acc = m_acc - 1;
                if (m_acc != 0) return;
                if (ph == tse_pkg::PH_CH_SID) after_session_id();
                else if (ph == tse_pkg::PH_CH_CS) after_suites();
                else if (ph == tse_pkg::PH_CH_COMP) after_compression();
                else next_extension();
            end
            tse_pkg::PH_CH_EXT_LEN: begin
                shift_in(b);
                if (m_cnt < 2) return;
                v = {8'd0, m_acc[15:0]};
                // an empty extension block is rejected
                if (m_msg < v || v == 0) begin halt_parse(); return; end
                m_ext = v[15:0];
                next_extension();
            end
            tse_pkg::PH_EXT_HDR: begin
                shift_in(b);
                // names left briefly holds the extension type
                if (m_cnt == 2) begin m_names = m_acc[15:0]; return; end
                if (m_cnt < 4) return;
                v = {8'd0, m_acc[15:0]};
                if (m_ext < v) halt_parse();
                else if (m_names == 0) begin
                    if (v < 2) halt_parse();
                    else begin
                        m_names = v[15:0];
                        open_field(tse_pkg::PH_SNI_LIST_LEN);
                    end
                end else if (v == 0) next_extension();
                else open_skip(tse_pkg::PH_EXT_SKIP, v);
            end
            tse_pkg::PH_SNI_LIST_LEN: begin
                shift_in(b);
                if (m_cnt < 2) return;
                v = {8'd0, m_acc[15:0]};
                if (m_names < 2 || v > m_names - 16'd2) begin halt_parse(); return; end
                m_names = v[15:0];
                next_name();
            end
            tse_pkg::PH_SNI_HDR: begin
                shift_in(b);
                if (m_cnt < 3) return;
                v = {8'd0, m_acc[15:0]};
                if (m_names < v) halt_parse();
                else if (v == 0) begin
                    push_result(tse_pkg::KIND_EMPTY_NAME, 8'd0, 1'b1, 1'b1, 16'd0);
                    next_name();
                end else open_skip(tse_pkg::PH_SNI_NAME, v);
            end
            tse_pkg::PH_SNI_NAME: begin
                push_result(tse_pkg::KIND_NAME_BYTE, b, m_cnt == 0, m_acc == 1, 16'd0);
                m_acc = m_acc - 1;
                m_cnt = m_cnt + 1;
                if (m_acc == 0) next_name();
            end
            default: halt_parse();
        endcase
    endfunction

    function automatic void predict_item(tse_pkg::t_in_item it);
        m_emitted = 0;
        if (it.payload_first) begin
            m_total = it.payload_len; m_left = it.payload_len; m_ckpt = 0;
            m_cnt = 0; m_acc = 0; m_rec = 0; m_rtype = 0;
            m_msg = 0; m_ext = 0; m_names = 0;
            if (it.payload_len == 0) begin
                m_phase = tse_pkg::PH_IDLE;
                push_result(tse_pkg::KIND_DONE, 8'd0, 1'b0, 1'b0, 16'd0);
                sni_results_q[$].run_last = 1'b1;
                return;
            end
            next_record();
        end else if (m_phase == tse_pkg::PH_IDLE) begin
            return;
        end
        parse_payload_byte(it.data_byte);
        if (m_left == 0) begin
            push_result(tse_pkg::KIND_DONE, 8'd0, 1'b0, 1'b0, m_ckpt);
            m_phase = tse_pkg::PH_IDLE;
        end
        if (m_emitted > 0) sni_results_q[$].run_last = 1'b1;
    endfunction

    // payload builder
    function automatic void put8(int v);
        pkt.push_back(v[7:0]);
    endfunction

    function automatic void put16(int v);
        put8(v >> 8); put8(v);
    endfunction

    function automatic void patch16(int at, int v);
        pkt[at] = v[15:8]; pkt[at + 1] = v[7:0];
    endfunction

    function automatic void add_client_hello();
        int rec_at, hs_at, ext_at, e_at, l_at, n;
        rec_at = pkt.size();
        put8(22); put8(3); put8(1); put16(0);
        hs_at = pkt.size();
        put8(1); put8(0); put16(0);
        repeat (34) put8($urandom);
        n = ($urandom_range(0, 15) == 0) ? 33 : $urandom_range(0, MaxSid);
        put8(n); repeat (n) put8($urandom);
        n = ($urandom_range(0, 9) == 0) ? 0 : 2 * $urandom_range(1, 4);
        put16(n); repeat (n) put8($urandom);
        n = $urandom_range(0, 2);
        put8(n); repeat (n) put8($urandom);
        ext_at = pkt.size();
        put16(0);
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 2) != 0) begin
                e_at = pkt.size();
                put16(0); put16(0);
                l_at = pkt.size();
                put16(0);
                repeat ($urandom_range(1, 2)) begin
                    n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    put8(0); put16(n);
                    repeat (n) put8($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(97, 122));
                end
                // trailing bytes inside the list are read as another server name entry header
                if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 5)) put8($urandom);
                patch16(l_at, pkt.size() - l_at - 2);
                patch16(e_at + 2, pkt.size() - e_at - 4);
            end else begin
                put16($urandom_range(1, 65535));
                n = $urandom_range(0, 6);
                put16(n); repeat (n) put8($urandom);
            end
        end
        patch16(ext_at, pkt.size() - ext_at - 2);
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 4)) put8($urandom);
        n = pkt.size() - hs_at - 4;
        pkt[hs_at + 1] = n[23:16]; patch16(hs_at + 2, n);
        patch16(rec_at + 3, pkt.size() - rec_at - 5);
    endfunction

    function automatic void add_record(int rtype, int n, logic alert);
        int k;
        put8(rtype); put8(3); put8(3); put16(n);
        for (k = 0; k < n; k++) begin
            if (alert)
                put8((k % 2 == 0) ? $urandom_range(1, 2) : (10 * $urandom_range(0, 2)));
            else
                put8($urandom);
        end
    endfunction

    function automatic void add_skipped_handshake();
        int n, t;
        n = $urandom_range(0, 8);
        case ($urandom_range(0, 3))
            0: t = 0;
            1: t = 2;
            2: t = $urandom_range(11, 16);
            default: t = 20;
        endcase
        put8(22); put8(3); put8(3); put16(n + 4);
        put8(t); put8(0); put16(n);
        repeat (n) put8($urandom);
    endfunction

    function automatic void queue_payload(int declared);
        tse_pkg::t_in_item it;
        int k;
        for (k = 0; k < pkt.size() || k == 0; k++) begin
            it.data_byte = (k < pkt.size()) ? pkt[k] : 8'($urandom);
            it.payload_first = (k == 0);
            it.payload_len = (k == 0) ? 16'(declared) : 16'($urandom);
            byte_feed.push_back(it);
            items_sent++;
        end
    endfunction

    function automatic void queue_stray_item();
        tse_pkg::t_in_item it;
        it.data_byte = 8'($urandom);
        it.payload_first = 1'b0;
        it.payload_len = 16'($urandom);
        byte_feed.push_back(it);
    endfunction

    function automatic void queue_random_payload();
        int declared, sel;
        pkt.delete();
        repeat ($urandom_range(1, 3)) begin
            sel = $urandom_range(0, 9);
            if (sel < 5) add_client_hello();
            else if (sel == 5) add_record(20, $urandom_range(0, 2), 1'b0);
            else if (sel == 6) add_record(23, $urandom_range(0, 20), 1'b0);
            else if (sel == 7) add_record(21, 2 * $urandom_range(0, 2), 1'b1);
            else if (sel == 8) add_skipped_handshake();
            else add_record($urandom, $urandom_range(0, 4), 1'b0);
        end
        if ($urandom_range(0, 6) == 0) pkt[$urandom_range(0, pkt.size() - 1)] = $urandom;
        if ($urandom_range(0, 15) == 0) repeat ($urandom_range(1, 3)) put8($urandom);
        declared = pkt.size();
        sel = $urandom_range(0, 19);
        if (sel == 0) declared = declared + $urandom_range(1, 40);
        else if (sel == 1) declared = $urandom_range(1, 65535);
        else if (sel == 2) while (pkt.size() > 1 && pkt.size() > declared / 2) void'(pkt.pop_back());
        if ($urandom_range(0, 9) == 0) queue_stray_item();
        queue_payload(declared);
    endfunction

    task automatic wait_quiet();
        do @(posedge i_clk);
        while (byte_feed.size() != 0 || push || sni_results_q.size() != 0);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_record_limit(logic [15:0] v);
        wait_quiet();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        m_max_rec = v;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= 16'($urandom);
    endtask

    // sender
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_item(i_in);
                void'(byte_feed.pop_front());
                send_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
            end
            if (!push || !full) begin
                if (send_gap > 0) begin
                    send_gap--;
                    push <= 1'b0;
                end else if (byte_feed.size() != 0) begin
                    push <= 1'b1;
                    i_in <= byte_feed[0];
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    int recv_gap = 0;
    int long_hold = 0;
    logic held_once = 1'b0;
    tse_pkg::t_out_item want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                rx_count++;
                if (sni_results_q.size() == 0) begin
                    $error("unexpected result beat kind %0d", o_out.kind);
                    errors++;
                end else begin
                    want = sni_results_q.pop_front();
                    if (o_out.kind != want.kind) begin
                        $error("kind exp %0d got %0d", want.kind, o_out.kind); errors++;
                    end
                    if (o_out.name_byte != want.name_byte) begin
                        $error("name_byte exp %0h got %0h", want.name_byte, o_out.name_byte);
                        errors++;
                    end
                    if (o_out.name_first != want.name_first) begin
                        $error("name_first exp %0d got %0d", want.name_first, o_out.name_first);
                        errors++;
                    end
                    if (o_out.name_last != want.name_last) begin
                        $error("name_last exp %0d got %0d", want.name_last, o_out.name_last);
                        errors++;
                    end
                    if (o_out.consumed != want.consumed) begin
                        $error("consumed exp %0d got %0d", want.consumed, o_out.consumed);
                        errors++;
                    end
                    if (o_out.run_last != want.run_last) begin
                        $error("run_last exp %0d got %0d", want.run_last, o_out.run_last);
                        errors++;
                    end
                end
                recv_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
                // one long hold-off so the queue fills and backs up the input
                if (rx_count == 80 && !held_once) begin
                    held_once = 1'b1;
                    long_hold = 400;
                end
            end
            if (long_hold > 0) begin
                long_hold--;
                pop <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    int stuck_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) stuck_cycles = 0;
            else stuck_cycles++;
            if (stuck_cycles >= IdleLimit) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    logic [15:0] limits[5] = '{16'h4000, 16'hFFFF, 16'd0, 16'd60, 16'd5};
    int ph;
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty payload, stray byte, short header, zero- and one-byte records, bad alert, short handshake
        pkt.delete(); queue_payload(0);
        queue_stray_item();
        pkt.delete(); put8(8'hFF); put8(8'hFF); put8(8'hFF); queue_payload(3);
        pkt.delete(); add_record(20, 0, 1'b0); add_record(23, 1, 1'b0); queue_payload(pkt.size());
        pkt.delete(); put8(21); put8(3); put8(3); put16(2); put8(3); put8(0);
        queue_payload(pkt.size());
        pkt.delete(); put8(22); put8(3); put8(3); put16(1); put8(1);
        queue_payload(pkt.size());

        for (ph = 0; ph < 5; ph++) begin
            write_record_limit((ph == 4) ? 16'($urandom_range(30, 400)) : limits[ph]);
            while (items_sent < (ph + 1) * PhaseItems) queue_random_payload();
        end
        wait_quiet();
        if (errors == 0 && sni_results_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
